// ===== hw/rtl/afd_pkg.sv =====
// Package for the API frame deframer: phase and status codes, frame constants
// and the word type passed from the input stage to the parser.
// No dependencies.
package afd_pkg;

  // Frame constants
  localparam logic [7:0] DELIMITER        = 8'h7E;
  localparam logic [7:0] SUM_GOOD         = 8'hFF;
  localparam logic [7:0] HUNT_LIMIT_RESET = 8'd30;
  localparam logic [7:0] COUNT_MAX        = 8'hFF;

  // Input word kinds
  localparam logic KIND_ATTN = 1'b0;
  localparam logic KIND_BYTE = 1'b1;

  // Parser phase
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HUNT    = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  // Result status
  typedef enum logic [1:0] {
    ST_PAYLOAD = 2'd0,
    ST_GOOD    = 2'd1,
    ST_BAD     = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  // One input word as held by the input stage
  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_word_t;

endpackage

// ===== hw/rtl/afd_in_if.sv =====
// Input channel of the API frame deframer: valid/ready plus one input word.
// No dependencies.
interface afd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

// ===== hw/rtl/afd_out_if.sv =====
// Result channel of the API frame deframer: valid/ready plus one result word.
// No dependencies.
interface afd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output status, output out_byte, output last, input ready);
  modport sink   (input valid, input status, input out_byte, input last, output ready);
endinterface

// ===== hw/rtl/afd_in_stage.sv =====
// Input register of the deframer: captures one word from the input channel
// and holds it until the parser takes it. Depends on afd_pkg, afd_in_if.
module afd_in_stage (
  input  logic              clk,
  input  logic              rst,
  afd_in_if.sink            in_ch,
  output logic              word_valid,
  output afd_pkg::in_word_t word,
  input  logic              take
);
  import afd_pkg::*;

  logic held;

  // Free when empty or when the held word leaves this cycle
  assign in_ch.ready = !held || take;
  assign word_valid  = held;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      held <= 1'b1;
    end else if (take) begin
      held <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      word.kind    <= in_ch.kind;
      word.rx_byte <= in_ch.rx_byte;
    end
  end

endmodule

// ===== hw/rtl/afd_parser.sv =====
// Frame parser of the deframer: phase register, hunt counter, length and
// running sum, with the result register on the output channel.
// Depends on afd_pkg, afd_out_if.
module afd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        hunt_limit,
  input  logic              word_valid,
  input  afd_pkg::in_word_t word,
  output logic              take,
  afd_out_if.source         out_ch
);
  import afd_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] hunt_count, hunt_count_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_sum, running_sum_next;

  logic       emit;
  status_t    res_status;
  logic [7:0] res_byte;
  logic       res_last;

  logic       out_valid;
  status_t    out_status;
  logic [7:0] out_byte;
  logic       out_last;

  logic       is_delim;
  logic [7:0] sum_add;
  logic [7:0] count_inc;

  // Take a word whenever the result register is free or draining
  assign take = word_valid && (!out_valid || out_ch.ready);

  assign is_delim  = (word.rx_byte == DELIMITER);
  assign sum_add   = running_sum + word.rx_byte;
  assign count_inc = (!is_delim && hunt_count != COUNT_MAX) ? hunt_count + 8'd1 : hunt_count;

  // Next state and result for the word on offer
  always_comb begin
    phase_next       = phase;
    hunt_count_next  = hunt_count;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    emit             = 1'b0;
    res_status       = ST_PAYLOAD;
    res_byte         = 8'd0;
    res_last         = 1'b0;

    if (word.kind == KIND_ATTN) begin
      // Attention starts a hunt only from idle (unused codes count as idle)
      case (phase)
        PH_HUNT, PH_LEN_HI, PH_LEN_LO, PH_PAYLOAD, PH_CHECK: begin
        end
        default: begin
          hunt_count_next  = 8'd0;
          running_sum_next = 8'd0;
          phase_next       = PH_HUNT;
        end
      endcase
    end else begin
      case (phase)
        PH_HUNT: begin
          if (is_delim && hunt_count < hunt_limit) begin
            phase_next = PH_LEN_HI;
          end else begin
            hunt_count_next = count_inc;
            if (is_delim || count_inc >= hunt_limit) begin
              phase_next = PH_IDLE;
              emit       = 1'b1;
              res_status = ST_TIMEOUT;
              res_last   = 1'b1;
            end
          end
        end
        PH_LEN_HI: begin
          phase_next = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          bytes_left_next = word.rx_byte;
          phase_next      = (word.rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          running_sum_next = sum_add;
          bytes_left_next  = bytes_left - 8'd1;
          if (bytes_left == 8'd1) begin
            phase_next = PH_CHECK;
          end
          emit     = 1'b1;
          res_byte = word.rx_byte;
        end
        PH_CHECK: begin
          running_sum_next = sum_add;
          phase_next       = PH_IDLE;
          emit             = 1'b1;
          res_status       = (sum_add == SUM_GOOD) ? ST_GOOD : ST_BAD;
          res_byte         = word.rx_byte;
          res_last         = 1'b1;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      hunt_count  <= 8'd0;
      bytes_left  <= 8'd0;
      running_sum <= 8'd0;
    end else if (take) begin
      phase       <= phase_next;
      hunt_count  <= hunt_count_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= emit;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_status <= res_status;
      out_byte   <= res_byte;
      out_last   <= res_last;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.status   = out_status;
  assign out_ch.out_byte = out_byte;
  assign out_ch.last     = out_last;

  // Checks
  a_end_to_idle: assert property (@(posedge clk) disable iff (rst)
    (take && emit && res_last) |=> (phase == PH_IDLE))
    else $error("frame end did not return to idle");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (take && word.kind == KIND_BYTE && phase == PH_PAYLOAD)
      |=> (bytes_left == $past(bytes_left) - 8'd1))
    else $error("payload count did not step down");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(take))
    else $error("result appeared without a word taken");

  a_last_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_status != ST_PAYLOAD)))
    else $error("last flag disagrees with status");

endmodule

// ===== hw/rtl/api_frame_deframer.sv =====
// Top level of the API frame deframer: hunt limit register, input stage and
// parser. Depends on afd_pkg, afd_in_if, afd_out_if, afd_in_stage, afd_parser.
//
//  channel   dir  handshake          payload
//  in_ch     in   valid / ready      kind, rx_byte
//  out_ch    out  valid / ready      status, out_byte, last
//  cfg       in   cfg_we (no ready)  cfg_data -> hunt_limit
//
// One word a cycle sustained while out_ch is ready; a word passes through the input
// register, then the result register, before its result appears.
// Synchronous reset clears phase, counters, the sum and both valid flags;
// hunt_limit returns to 30.
// A stalled result holds the result register; the input register still takes
// one more word, then ready drops until the result drains.
module api_frame_deframer (
  input  logic       clk,
  input  logic       rst,
  afd_in_if.sink     in_ch,
  afd_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);
  import afd_pkg::*;

  logic       [7:0] hunt_limit;
  logic             word_valid;
  in_word_t         word;
  logic             take;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      hunt_limit <= HUNT_LIMIT_RESET;
    end else if (cfg_we) begin
      hunt_limit <= cfg_data;
    end
  end

  afd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .word_valid (word_valid),
    .word       (word),
    .take       (take)
  );

  afd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .hunt_limit (hunt_limit),
    .word_valid (word_valid),
    .word       (word),
    .take       (take),
    .out_ch     (out_ch)
  );

endmodule
